FILE: sv/bmws_pkg.sv
// Shared constants and types of the binary map box window sum block
`default_nettype none

package bmws_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_WINDOW = 32;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int WIN_REG_W = 6;
  localparam int COUNT_W   = 11;
  localparam int POS_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = CFG_IDX_W'(3);

  localparam int RST_FRAME_WIDTH   = 1024;
  localparam int RST_FRAME_HEIGHT  = 1024;
  localparam int RST_WINDOW_WIDTH  = 3;
  localparam int RST_WINDOW_HEIGHT = 3;

  // power of two
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic             blocked;
    logic             row_zero;
    logic             vsub;
    logic             hfirst;
    logic             hsub;
    logic             emit;
    logic             last;
    logic [POS_W-1:0] top_row;
    logic [POS_W-1:0] left_col;
  } ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   top_row;
    logic [POS_W-1:0]   left_col;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/binary_map_box_window_sum.sv
// Top level: raster counters, size registers, column stage, window chain, result queue
// A result passes the column read register, column output register and result queue.
// Throughput: one cell per cycle, set by the column memory read-modify-write (forwarded
// when the same column follows directly) and the 4-entry result queue under back-pressure.
// Reset: counters zero, size registers 1024/1024/3/3; the column sums and row history
// in the column memory are not cleared, each frame writes them before it reads them.
`default_nettype none

module binary_map_box_window_sum #(
  parameter int MAX_WIDTH  = bmws_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmws_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = bmws_pkg::DEF_MAX_WINDOW
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire [bmws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bmws_pkg::CFG_W-1:0]         cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               is_blocked,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [bmws_pkg::COUNT_W-1:0]      window_count,
  output logic [bmws_pkg::POS_W-1:0]        top_row,
  output logic [bmws_pkg::POS_W-1:0]        left_col,
  output logic                              last_of_frame
);

  import bmws_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int FW_W   = $clog2(MAX_WIDTH + 1);
  localparam int FH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int WN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CS_W   = WN_W;
  localparam int MW1    = (FW_W > FH_W) ? FW_W : FH_W;
  localparam int CW     = ((MW1 > CFG_W) ? MW1 : CFG_W) + 1;
  localparam int LW     = OUT_CNT_W + 1;

  localparam int FW_RST = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int FH_RST = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;
  localparam int WW_RST = (RST_WINDOW_WIDTH > MAX_WINDOW) ? MAX_WINDOW : RST_WINDOW_WIDTH;
  localparam int WH_RST = (RST_WINDOW_HEIGHT > MAX_WINDOW) ? MAX_WINDOW : RST_WINDOW_HEIGHT;

  function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v,
                                               input logic [CW-1:0] hi);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [FW_W-1:0]      cfg_fw;
  logic [FH_W-1:0]      cfg_fh;
  logic [WN_W-1:0]      cfg_ww;
  logic [WN_W-1:0]      cfg_wh;
  logic [FW_W-1:0]      act_fw;
  logic [FH_W-1:0]      act_fh;
  logic [WN_W-1:0]      act_ww;
  logic [WN_W-1:0]      act_wh;
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [SLOT_W-1:0]    vslot;

  logic                 accept;
  logic                 first;
  logic [FW_W-1:0]      fw;
  logic [FH_W-1:0]      fh;
  logic [WN_W-1:0]      ww;
  logic [WN_W-1:0]      wh;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    slot_inc;
  logic [SLOT_W-1:0]    tap;
  logic [CW-1:0]        row_c;
  logic [CW-1:0]        col_c;
  logic                 row_end;
  logic                 frame_end;
  ctl_t                 item_ctl;

  logic                 col_busy;
  logic                 col_valid;
  logic [CS_W-1:0]      col_sum;
  logic [SLOT_W-1:0]    col_tap;
  ctl_t                 col_ctl;
  logic                 res_push;
  res_t                 res;
  res_t                 head;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic                 fifo_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_fw <= FW_W'(FW_RST);
      cfg_fh <= FH_W'(FH_RST);
      cfg_ww <= WN_W'(WW_RST);
      cfg_wh <= WN_W'(WH_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   cfg_fw <= FW_W'(clamp_size(CW'(cfg_data), CW'(MAX_WIDTH)));
        REG_FRAME_HEIGHT:  cfg_fh <= FH_W'(clamp_size(CW'(cfg_data), CW'(MAX_HEIGHT)));
        REG_WINDOW_WIDTH:  cfg_ww <= WN_W'(clamp_size(CW'(cfg_data[WIN_REG_W-1:0]),
                                                      CW'(MAX_WINDOW)));
        REG_WINDOW_HEIGHT: cfg_wh <= WN_W'(clamp_size(CW'(cfg_data[WIN_REG_W-1:0]),
                                                      CW'(MAX_WINDOW)));
        default: ;
      endcase
    end
  end

  always_comb begin
    accept    = in_valid && in_ready;
    first     = (row == '0) && (col == '0);
    fw        = first ? cfg_fw : act_fw;
    fh        = first ? cfg_fh : act_fh;
    ww        = first ? cfg_ww : act_ww;
    wh        = first ? cfg_wh : act_wh;
    slot      = first ? '0 : vslot;
    row_c     = CW'(row);
    col_c     = CW'(col);
    row_end   = (col_c + 1'b1) >= CW'(fw);
    frame_end = row_end && ((row_c + 1'b1) >= CW'(fh));
    slot_inc  = ((CW'(slot) + 1'b1) == CW'(wh)) ? '0 : SLOT_W'(slot + 1'b1);
    tap       = SLOT_W'(CW'(ww) - CW'(1));

    item_ctl.blocked  = is_blocked;
    item_ctl.row_zero = (row == '0);
    item_ctl.vsub     = row_c >= CW'(wh);
    item_ctl.hfirst   = (col == '0);
    item_ctl.hsub     = col_c >= CW'(ww);
    item_ctl.emit     = (CW'(ww) <= CW'(fw)) && (CW'(wh) <= CW'(fh)) &&
                        ((row_c + 1'b1) >= CW'(wh)) && ((col_c + 1'b1) >= CW'(ww));
    item_ctl.last     = ((row_c + 1'b1) == CW'(fh)) && ((col_c + 1'b1) == CW'(fw));
    item_ctl.top_row  = POS_W'(row_c + 1'b1 - CW'(wh));
    item_ctl.left_col = POS_W'(col_c + 1'b1 - CW'(ww));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      col    <= '0;
      vslot  <= '0;
      act_fw <= FW_W'(FW_RST);
      act_fh <= FH_W'(FH_RST);
      act_ww <= WN_W'(WW_RST);
      act_wh <= WN_W'(WH_RST);
    end else if (accept) begin
      if (first) begin
        act_fw <= cfg_fw;
        act_fh <= cfg_fh;
        act_ww <= cfg_ww;
        act_wh <= cfg_wh;
      end
      if (row_end) begin
        col <= '0;
        if (frame_end) begin
          row   <= '0;
          vslot <= '0;
        end else begin
          row   <= ROW_W'(row_c + 1'b1);
          vslot <= slot_inc;
        end
      end else begin
        col <= COL_W'(col_c + 1'b1);
      end
    end
  end

  bmws_column #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_column (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .in_col     (col),
    .in_slot    (slot),
    .in_tap     (tap),
    .in_ctl     (item_ctl),
    .busy       (col_busy),
    .out_valid  (col_valid),
    .out_colsum (col_sum),
    .out_tap    (col_tap),
    .out_ctl    (col_ctl)
  );

  bmws_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (col_valid),
    .in_colsum (col_sum),
    .in_tap    (col_tap),
    .in_ctl    (col_ctl),
    .push      (res_push),
    .push_res  (res)
  );

  bmws_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_res (res),
    .pop      (fifo_valid && out_ready),
    .valid    (fifo_valid),
    .head     (head),
    .count    (fifo_count)
  );

  // queue space covers every transfer still in the pipeline
  assign in_ready = (LW'(fifo_count) + LW'(col_busy) + LW'(col_valid)) < LW'(OUT_DEPTH);

  assign out_valid     = fifo_valid;
  assign window_count  = head.count;
  assign top_row       = head.top_row;
  assign left_col      = head.left_col;
  assign last_of_frame = head.last;

  assert property (@(posedge clk) disable iff (rst)
    accept && item_ctl.last |-> frame_end)
    else $error("last window flagged away from frame end");

  assert property (@(posedge clk) disable iff (rst)
    CW'(col) < CW'(act_fw))
    else $error("column counter beyond active frame width");

  assert property (@(posedge clk) disable iff (rst)
    CW'(vslot) < CW'(act_wh))
    else $error("history slot beyond active window height");

  assert property (@(posedge clk) disable iff (rst)
    res_push |-> $past(col_busy))
    else $error("result pushed without a transfer in the column stage");

  assert property (@(posedge clk) disable iff (rst)
    LW'(fifo_count) <= LW'(OUT_DEPTH))
    else $error("result queue overflow");

endmodule

`default_nettype wire

FILE: sv/bmws_cell.sv
// One cell of the column sum shift chain with its tap select
`default_nettype none

module bmws_cell #(
  parameter int W     = 6,
  parameter int SEL_W = 5,
  parameter int IDX   = 0
) (
  input  wire             clk,
  input  wire             shift,
  input  wire [SEL_W-1:0] tap,
  input  wire [W-1:0]     din,
  output logic [W-1:0]    dout,
  output logic [W-1:0]    drop
);

  logic [W-1:0] value;

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= din;
    end
  end

  assign dout = value;
  assign drop = (tap == SEL_W'(IDX)) ? value : '0;

endmodule

`default_nettype wire

FILE: sv/bmws_column.sv
// Per-column running sums and row history, read-modify-write with forwarding
`default_nettype none

module bmws_column #(
  parameter int MAX_WIDTH  = bmws_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = bmws_pkg::DEF_MAX_WINDOW,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int CS_W   = $clog2(MAX_WINDOW + 1)
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  wire [COL_W-1:0]       in_col,
  input  wire [SLOT_W-1:0]      in_slot,
  input  wire [SLOT_W-1:0]      in_tap,
  input  wire bmws_pkg::ctl_t   in_ctl,
  output logic                  busy,
  output logic                  out_valid,
  output logic [CS_W-1:0]       out_colsum,
  output logic [SLOT_W-1:0]     out_tap,
  output bmws_pkg::ctl_t        out_ctl
);

  import bmws_pkg::*;

  localparam int WORD_W = MAX_WINDOW + CS_W;

  logic [WORD_W-1:0]     mem [MAX_WIDTH];
  logic [WORD_W-1:0]     rdata;
  logic [WORD_W-1:0]     last_word;
  logic [WORD_W-1:0]     word;
  logic [WORD_W-1:0]     wdata;
  logic                  s1_valid;
  logic                  fwd;
  logic [COL_W-1:0]      s1_col;
  logic [SLOT_W-1:0]     s1_slot;
  logic [SLOT_W-1:0]     s1_tap;
  ctl_t                  s1_ctl;
  logic [MAX_WINDOW-1:0] hist;
  logic [MAX_WINDOW-1:0] hist_next;
  logic [CS_W-1:0]       cs_old;
  logic [CS_W-1:0]       cs_new;
  logic                  old_bit;

  always_ff @(posedge clk) begin
    if (in_valid) begin
      rdata <= mem[in_col];
    end
    if (s1_valid) begin
      mem[s1_col] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_col  <= in_col;
      s1_slot <= in_slot;
      s1_tap  <= in_tap;
      s1_ctl  <= in_ctl;
      // same column written at this edge: memory read is stale
      fwd     <= s1_valid && (s1_col == in_col);
    end
    if (s1_valid) begin
      last_word  <= wdata;
      out_colsum <= cs_new;
      out_tap    <= s1_tap;
      out_ctl    <= s1_ctl;
    end
  end

  always_comb begin
    word      = fwd ? last_word : rdata;
    hist      = word[WORD_W-1:CS_W];
    cs_old    = s1_ctl.row_zero ? '0 : word[CS_W-1:0];
    old_bit   = s1_ctl.vsub ? hist[s1_slot] : 1'b0;
    cs_new    = cs_old + CS_W'(s1_ctl.blocked) - CS_W'(old_bit);
    hist_next = hist;
    hist_next[s1_slot] = s1_ctl.blocked;
    wdata     = {hist_next, cs_new};
  end

  assign busy = s1_valid;

endmodule

`default_nettype wire

FILE: sv/bmws_window.sv
// Horizontal running sum over a shift chain of column sums
`default_nettype none

module bmws_window #(
  parameter int MAX_WINDOW = bmws_pkg::DEF_MAX_WINDOW,
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int CS_W   = $clog2(MAX_WINDOW + 1)
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire [CS_W-1:0]      in_colsum,
  input  wire [SLOT_W-1:0]    in_tap,
  input  wire bmws_pkg::ctl_t in_ctl,
  output logic                push,
  output bmws_pkg::res_t      push_res
);

  import bmws_pkg::*;

  localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

  logic [CS_W-1:0]  link  [MAX_WINDOW+1];
  logic [CS_W-1:0]  drops [MAX_WINDOW];
  logic [CS_W-1:0]  drop;
  logic [SUM_W-1:0] running;
  logic [SUM_W-1:0] sum_next;

  assign link[0] = in_colsum;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    bmws_cell #(
      .W     (CS_W),
      .SEL_W (SLOT_W),
      .IDX   (k)
    ) u_cell (
      .clk   (clk),
      .shift (in_valid),
      .tap   (in_tap),
      .din   (link[k]),
      .dout  (link[k+1]),
      .drop  (drops[k])
    );
  end

  always_comb begin
    drop = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      drop = drop | drops[k];
    end
  end

  always_comb begin
    if (in_ctl.hfirst) begin
      sum_next = SUM_W'(in_colsum);
    end else begin
      sum_next = running + SUM_W'(in_colsum) - (in_ctl.hsub ? SUM_W'(drop) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (in_valid) begin
      running <= sum_next;
    end
  end

  always_comb begin
    push              = in_valid && in_ctl.emit;
    push_res.count    = COUNT_W'(sum_next);
    push_res.top_row  = in_ctl.top_row;
    push_res.left_col = in_ctl.left_col;
    push_res.last     = in_ctl.last;
  end

endmodule

`default_nettype wire

FILE: sv/bmws_fifo.sv
// Result queue between the window pipeline and the output channel
`default_nettype none

module bmws_fifo (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push,
  input  wire bmws_pkg::res_t               push_res,
  input  wire                               pop,
  output logic                              valid,
  output bmws_pkg::res_t                    head,
  output logic [bmws_pkg::OUT_CNT_W-1:0]    count
);

  import bmws_pkg::*;

  res_t                 slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

endmodule

`default_nettype wire
